// ===== rtl/core/ogs_pkg.sv =====
`timescale 1ns / 1ps

package ogs_pkg;

  localparam int PAGE_COUNT   = 4;
  localparam int COLUMN_COUNT = 128;

  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int COL_W  = 7;
  localparam int STEP_W = 4;
  localparam int IDX_W  = 7;
  localparam int GCOL_W = 3;

  // Controller command codes
  localparam logic [7:0] CMD_COLUMN_ADDR = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR   = 8'h22;
  localparam logic [7:0] BLANK_COLUMN    = 8'h00;

  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_FIRST     = 8'h20;
  localparam logic [7:0] CHAR_LAST      = 8'h7E;
  localparam logic [IDX_W-1:0] BOX_INDEX = IDX_W'(8'h7F - 8'h20);
  localparam logic [COL_W-1:0] CELL_WIDTH = COL_W'(6);

  localparam logic [0:0] REQ_PRINT      = 1'b0;

  // Byte positions inside the twelve-byte sequence of one item
  localparam logic [STEP_W-1:0] STEP_CMD_FIRST   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_COL_VALUE   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_COL_END     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_PAGE_CMD    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_PAGE_VALUE  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CMD_LAST    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_GLYPH_FIRST = 4'd6;
  localparam logic [STEP_W-1:0] STEP_LAST        = 4'd11;

  typedef struct packed {
    logic [0:0] req_type;
    logic [7:0] char_code;
    logic [7:0] page_sel;
    logic [7:0] column_sel;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [GCOL_W-1:0] col;
  } rom_rd_t;

  typedef struct packed {
    logic       valid;
    logic       use_rom;
    logic [7:0] cmd_byte;
    logic       is_data;
    logic       last;
  } out_ctl_t;

  // Five columns per glyph, leftmost column in the top byte
  localparam logic [39:0] GLYPH_ROM [0:95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E4149493A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h086E414100,
    40'h00007F0000, 40'h0041416E08, 40'h0402040804, 40'h7F4141417F
  };

endpackage

// ===== rtl/core/ogs_font_rom.sv =====
`timescale 1ns / 1ps

module ogs_font_rom (
  input  logic             clk,
  input  ogs_pkg::rom_rd_t rd,
  output logic [7:0]       q
);

  logic [39:0] entry;

  assign entry = (rd.idx < ogs_pkg::IDX_W'(96)) ? ogs_pkg::GLYPH_ROM[rd.idx] : 40'h0;

  // Registered read; hold the last byte while not enabled
  always_ff @(posedge clk) begin
    if (rd.en) begin
      case (rd.col)
        3'd0:    q <= entry[39:32];
        3'd1:    q <= entry[31:24];
        3'd2:    q <= entry[23:16];
        3'd3:    q <= entry[15:8];
        3'd4:    q <= entry[7:0];
        default: q <= 8'h00;
      endcase
    end
  end

endmodule

// ===== rtl/core/ogs_seq.sv =====
`timescale 1ns / 1ps

module ogs_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ogs_pkg::item_t      item,
  input  logic                out_ready,
  output ogs_pkg::rom_rd_t    rom_rd,
  output ogs_pkg::out_ctl_t   out_ctl
);

  localparam int PW = ogs_pkg::PAGE_W;
  localparam int CW = ogs_pkg::COL_W;

  logic                        buf_valid;
  ogs_pkg::item_t              buf_item;

  logic [PW-1:0]               cursor_page;
  logic [CW-1:0]               cursor_column;

  logic                        busy;
  logic [ogs_pkg::STEP_W-1:0]  step;
  logic [ogs_pkg::STEP_W-1:0]  end_step;
  logic [PW-1:0]               cmd_page;
  logic [CW-1:0]               cmd_column;
  logic [ogs_pkg::IDX_W-1:0]   glyph_idx;

  logic advance, issue, at_end, load;

  // Plan of the buffered item against the current cursor
  logic [PW-1:0]               next_pg;
  logic                        is_newline, wrap;
  logic                        plan_cmd, plan_glyph;
  logic [PW-1:0]               plan_page;
  logic [CW-1:0]               plan_column;
  logic [ogs_pkg::IDX_W-1:0]   plan_idx;
  logic [PW-1:0]               cursor_page_next;
  logic [CW-1:0]               cursor_column_next;

  logic [7:0]                  step_byte;
  logic                        step_rom, step_data;

  assign advance  = !out_ctl.valid || out_ready;
  assign issue    = advance && busy;
  assign at_end   = busy && (step == end_step);
  assign load     = buf_valid && (!busy || (issue && at_end));
  assign in_ready = !buf_valid;

  assign next_pg = (cursor_page == PW'(ogs_pkg::PAGE_COUNT - 1)) ? '0 : cursor_page + PW'(1);
  assign is_newline = (buf_item.char_code == ogs_pkg::CHAR_CR) ||
                      (buf_item.char_code == ogs_pkg::CHAR_LF);
  assign wrap = ({1'b0, cursor_column} + 8'(ogs_pkg::CELL_WIDTH)) >=
                8'(ogs_pkg::COLUMN_COUNT);

  always_comb begin
    plan_idx = ogs_pkg::BOX_INDEX;
    if (buf_item.char_code >= ogs_pkg::CHAR_FIRST && buf_item.char_code <= ogs_pkg::CHAR_LAST) begin
      plan_idx = ogs_pkg::IDX_W'(buf_item.char_code - ogs_pkg::CHAR_FIRST);
    end
    if (buf_item.req_type != ogs_pkg::REQ_PRINT) begin
      // Clamp an out-of-range position to zero
      plan_cmd    = 1'b1;
      plan_glyph  = 1'b0;
      plan_page   = (buf_item.page_sel > 8'(ogs_pkg::PAGE_COUNT - 1)) ?
                    '0 : buf_item.page_sel[PW-1:0];
      plan_column = (buf_item.column_sel > 8'(ogs_pkg::COLUMN_COUNT - 1)) ?
                    '0 : buf_item.column_sel[CW-1:0];
      cursor_page_next   = plan_page;
      cursor_column_next = plan_column;
    end else if (is_newline) begin
      plan_cmd    = 1'b1;
      plan_glyph  = 1'b0;
      plan_page   = next_pg;
      plan_column = '0;
      cursor_page_next   = next_pg;
      cursor_column_next = '0;
    end else begin
      plan_cmd    = wrap;
      plan_glyph  = 1'b1;
      plan_page   = next_pg;
      plan_column = '0;
      cursor_page_next   = wrap ? next_pg : cursor_page;
      cursor_column_next = (wrap ? CW'(0) : cursor_column) + ogs_pkg::CELL_WIDTH;
    end
  end

  // Byte for the step being issued
  always_comb begin
    step_rom  = 1'b0;
    step_data = 1'b0;
    case (step)
      ogs_pkg::STEP_CMD_FIRST:  step_byte = ogs_pkg::CMD_COLUMN_ADDR;
      ogs_pkg::STEP_COL_VALUE:  step_byte = 8'(cmd_column);
      ogs_pkg::STEP_COL_END:    step_byte = 8'(ogs_pkg::COLUMN_COUNT - 1);
      ogs_pkg::STEP_PAGE_CMD:   step_byte = ogs_pkg::CMD_PAGE_ADDR;
      ogs_pkg::STEP_PAGE_VALUE: step_byte = 8'(cmd_page);
      ogs_pkg::STEP_CMD_LAST:   step_byte = 8'(ogs_pkg::PAGE_COUNT - 1);
      ogs_pkg::STEP_LAST: begin
        step_byte = ogs_pkg::BLANK_COLUMN;
        step_data = 1'b1;
      end
      default: begin
        step_byte = ogs_pkg::BLANK_COLUMN;
        step_rom  = 1'b1;
        step_data = 1'b1;
      end
    endcase
  end

  assign rom_rd.en  = issue;
  assign rom_rd.idx = glyph_idx;
  assign rom_rd.col = ogs_pkg::GCOL_W'(step - ogs_pkg::STEP_GLYPH_FIRST);

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid     <= 1'b0;
      busy          <= 1'b0;
      cursor_page   <= '0;
      cursor_column <= '0;
      out_ctl.valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        buf_valid <= 1'b1;
        buf_item  <= item;
      end else if (load) begin
        buf_valid <= 1'b0;
      end

      if (advance) begin
        out_ctl.valid    <= issue;
        out_ctl.use_rom  <= step_rom;
        out_ctl.cmd_byte <= step_byte;
        out_ctl.is_data  <= step_data;
        out_ctl.last     <= at_end;
      end

      // Start the buffered item, or advance the current one
      if (load) begin
        busy          <= 1'b1;
        step          <= plan_cmd ? ogs_pkg::STEP_CMD_FIRST : ogs_pkg::STEP_GLYPH_FIRST;
        end_step      <= plan_glyph ? ogs_pkg::STEP_LAST : ogs_pkg::STEP_CMD_LAST;
        cmd_page      <= plan_page;
        cmd_column    <= plan_column;
        glyph_idx     <= plan_idx;
        cursor_page   <= cursor_page_next;
        cursor_column <= cursor_column_next;
      end else if (issue) begin
        if (at_end) begin
          busy <= 1'b0;
        end else begin
          step <= step + ogs_pkg::STEP_W'(1);
        end
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step <= end_step) && (end_step <= ogs_pkg::STEP_LAST))
    else $error("step counter past end of item");

  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(cursor_page) && $stable(cursor_column))
    else $error("cursor moved without an item load");

  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && (step == ogs_pkg::STEP_CMD_FIRST || step == ogs_pkg::STEP_GLYPH_FIRST))
    else $error("item did not start at a group boundary");

endmodule

// ===== rtl/core/oled_text_glyph_streamer.sv =====
`timescale 1ns / 1ps

// Character-to-byte streamer for a 128x32 page-addressed OLED controller.
// Each input transfer is either a character (req_type 0) or a cursor set
// (req_type 1). A cursor move sends six command bytes (column address 0x21,
// column, last column, page address 0x22, page, last page); a printable
// character sends five glyph columns from the 5x8 font ROM plus one blank
// column, wrapping to the next page first when six or fewer columns remain.
// CR and LF start a new page; codes outside 0x20..0x7E show as a box.
// Output runs one byte per cycle while out_ready is high: an item is six
// bytes (cursor move or unwrapped character) or twelve (wrapped character),
// set by the byte sequencer, which walks one step per output transfer. A
// one-entry input buffer takes the next item while the current one streams,
// and the next item starts in the cycle after the current one's last byte
// issues, so a busy stream has no gaps. Glyph bytes come from a ROM with a
// registered read that doubles as the output register. An item taken while
// idle passes the input buffer and step register before its first output
// byte. out_ready low holds the current byte and freezes the sequencer.

module oled_text_glyph_streamer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [0:0] req_type,
  input  logic [7:0] char_code,
  input  logic [7:0] page_sel,
  input  logic [7:0] column_sel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       last
);

  ogs_pkg::item_t    item;
  ogs_pkg::rom_rd_t  rom_rd;
  ogs_pkg::out_ctl_t out_ctl;
  logic [7:0]        rom_q;

  assign item.req_type   = req_type;
  assign item.char_code  = char_code;
  assign item.page_sel   = page_sel;
  assign item.column_sel = column_sel;

  // Sequencer: holds cursor, plans items, one byte a cycle unless stalled
  ogs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item      (item),
    .out_ready (out_ready),
    .rom_rd    (rom_rd),
    .out_ctl   (out_ctl)
  );

  // Font ROM, read in step with the output register
  ogs_font_rom u_rom (
    .clk (clk),
    .rd  (rom_rd),
    .q   (rom_q)
  );

  // Pick glyph data from the ROM, commands and blank column from the sequencer
  assign out_valid = out_ctl.valid;
  assign out_byte  = out_ctl.use_rom ? rom_q : out_ctl.cmd_byte;
  assign is_data   = out_ctl.is_data;
  assign last      = out_ctl.last;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ogs_pkg::*;

  // Request kind that moves the cursor; printing uses REQ_PRINT from the package
  localparam logic [0:0] REQ_SET_CURSOR = 1'b1;

  localparam int GLYPH_COLUMNS    = 5;
  localparam int LIMIT_CYCLES     = 200000;
  localparam int TAIL_CYCLES      = 32;
  localparam int RANDOM_PER_PHASE = 135;

  // 5x8 font, space through tilde plus the box glyph; leftmost column in the top byte
  localparam logic [39:0] GLYPH_BITMAPS [0:95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E4149493A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
    40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h086E414100,
    40'h00007F0000, 40'h0041416E08, 40'h0402040804, 40'h7F4141417F
  };

  // One byte headed for the display controller
  typedef struct packed {
    logic [7:0] value;
    logic       data_flag;
    logic       last_flag;
  } display_byte_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [0:0] req_type;
  logic [7:0] char_code;
  logic [7:0] page_sel;
  logic [7:0] column_sel;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  // Bytes the display should see, oldest first
  display_byte_t pending_bytes [$];

  // Cursor as the display should track it
  logic [PAGE_W-1:0] cursor_page;
  logic [COL_W-1:0]  cursor_column;

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int cycle_count;

  oled_text_glyph_streamer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .char_code (char_code),
    .page_sel  (page_sel),
    .column_sel(column_sel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung stream ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: drop ready at random, at the rate of the current phase
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Byte stream prediction
  // ---------------------------------------------------------------------------

  task automatic push_display_byte(input logic [7:0] value, input logic data_flag,
                                   input logic last_flag);
    display_byte_t entry;
    entry.value     = value;
    entry.data_flag = data_flag;
    entry.last_flag = last_flag;
    pending_bytes.push_back(entry);
  endtask

  // Move the cursor and queue the six address commands. ends_item flags the
  // page-end byte as the final one when no glyph follows.
  task automatic queue_cursor_move(input logic [PAGE_W-1:0] page,
                                   input logic [COL_W-1:0] column, input logic ends_item);
    cursor_page   = page;
    cursor_column = column;
    push_display_byte(CMD_COLUMN_ADDR, 1'b0, 1'b0);
    push_display_byte(8'(column), 1'b0, 1'b0);
    push_display_byte(8'(COLUMN_COUNT - 1), 1'b0, 1'b0);
    push_display_byte(CMD_PAGE_ADDR, 1'b0, 1'b0);
    push_display_byte(8'(page), 1'b0, 1'b0);
    push_display_byte(8'(PAGE_COUNT - 1), 1'b0, ends_item);
  endtask

  // Work out every byte one accepted request causes and advance the cursor
  task automatic predict_display_bytes(input logic [0:0] kind, input logic [7:0] code,
                                       input logic [7:0] page, input logic [7:0] column);
    logic [PAGE_W-1:0] following_page;
    logic [39:0]       bitmap;
    int                glyph;
    int                k;
    following_page = PAGE_W'((int'(cursor_page) + 1) % PAGE_COUNT);
    if (kind == REQ_SET_CURSOR) begin
      // Out-of-range page or column falls back to zero
      queue_cursor_move((page > PAGE_COUNT - 1) ? '0 : PAGE_W'(page),
                        (column > COLUMN_COUNT - 1) ? '0 : COL_W'(column), 1'b1);
    end else if (code == CHAR_CR || code == CHAR_LF) begin
      queue_cursor_move(following_page, '0, 1'b1);
    end else begin
      // Wrap first when six or fewer columns remain on this line
      if (int'(cursor_column) + int'(CELL_WIDTH) >= COLUMN_COUNT) begin
        queue_cursor_move(following_page, '0, 1'b0);
      end
      glyph  = (code >= CHAR_FIRST && code <= CHAR_LAST) ? int'(code - CHAR_FIRST)
                                                         : int'(BOX_INDEX);
      bitmap = GLYPH_BITMAPS[glyph];
      for (k = 0; k < GLYPH_COLUMNS; k++) begin
        push_display_byte(bitmap[39 - 8 * k -: 8], 1'b1, 1'b0);
      end
      push_display_byte(BLANK_COLUMN, 1'b1, 1'b1);
      cursor_column = cursor_column + CELL_WIDTH;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output check: compare every output transfer with the oldest pending byte
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_output
    display_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("output transfer with nothing pending: out_byte=%02h is_data=%0b last=%0b",
               out_byte, is_data, last);
        error_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.value) begin
          $error("out_byte: expected %02h, got %02h", want.value, out_byte);
          error_count++;
        end
        if (is_data !== want.data_flag) begin
          $error("is_data: expected %0b, got %0b", want.data_flag, is_data);
          error_count++;
        end
        if (last !== want.last_flag) begin
          $error("last: expected %0b, got %0b", want.last_flag, last);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Present one request, idling first at the sender's rate; predict on transfer.
  // Valid stays high past the transfer until the next falling edge decides.
  task automatic send_request(input logic [0:0] kind, input logic [7:0] code,
                              input logic [7:0] page, input logic [7:0] column);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    char_code  <= code;
    page_sel   <= page;
    column_sel <= column;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_display_bytes(kind, code, page, column);
  endtask

  // Drop valid and hold off until the display has every byte it is owed
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_value();
    return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Printable range ends, a plain letter, and unprintable codes drawn as a box;
  // the unused page and column fields carry junk that must be ignored
  task automatic test_glyph_extremes();
    send_request(REQ_PRINT, CHAR_FIRST, 8'hFF, 8'hFF);
    send_request(REQ_PRINT, CHAR_LAST, 8'h00, 8'h80);
    send_request(REQ_PRINT, 8'h41, any_value(), any_value());
    send_request(REQ_PRINT, 8'h7F, any_value(), any_value());
    send_request(REQ_PRINT, 8'hFF, any_value(), any_value());
    send_request(REQ_PRINT, 8'h00, any_value(), any_value());
    send_request(REQ_PRINT, 8'h1F, any_value(), any_value());
    send_request(REQ_PRINT, 8'h80, any_value(), any_value());
  endtask

  // CR and LF walk the cursor through every page and back to page zero
  task automatic test_new_line();
    send_request(REQ_PRINT, CHAR_CR, 8'h03, 8'h7F);
    send_request(REQ_PRINT, CHAR_LF, any_value(), any_value());
    send_request(REQ_PRINT, CHAR_CR, any_value(), any_value());
    send_request(REQ_PRINT, CHAR_LF, any_value(), any_value());
  endtask

  // Highest legal cursor, just out of range, all ones, all zeros;
  // char_code holds CR, LF and other codes that the set request must ignore
  task automatic test_cursor_set();
    send_request(REQ_SET_CURSOR, CHAR_CR, 8'(PAGE_COUNT - 1), 8'(COLUMN_COUNT - 1));
    send_request(REQ_SET_CURSOR, CHAR_LF, 8'(PAGE_COUNT), 8'(COLUMN_COUNT));
    send_request(REQ_SET_CURSOR, 8'hFF, 8'hFF, 8'hFF);
    send_request(REQ_SET_CURSOR, 8'h00, 8'h00, 8'h00);
  endtask

  // Line wrap at the boundary: first wrapping column, last fitting column,
  // a wrap from the last page, and a new line from the last page
  task automatic test_line_wrap();
    send_request(REQ_SET_CURSOR, any_value(), 8'd3, 8'(COLUMN_COUNT - 6));
    send_request(REQ_PRINT, 8'h57, any_value(), any_value());
    send_request(REQ_SET_CURSOR, any_value(), 8'd1, 8'(COLUMN_COUNT - 7));
    send_request(REQ_PRINT, 8'h31, any_value(), any_value());
    send_request(REQ_PRINT, 8'h32, any_value(), any_value());
    send_request(REQ_SET_CURSOR, any_value(), 8'd3, 8'd5);
    send_request(REQ_PRINT, CHAR_LF, any_value(), any_value());
  endtask

  // Mostly printable text so lines fill and wrap, with new lines, odd codes,
  // cursor moves near the right edge, and raw cursor requests mixed in
  task automatic test_random_traffic(input int count);
    int         n;
    int         pick;
    logic [7:0] code;
    logic [7:0] page;
    logic [7:0] column;
    for (n = 0; n < count; n++) begin
      pick   = $urandom_range(99);
      code   = any_value();
      page   = any_value();
      column = any_value();
      if (pick < 50) begin
        code = 8'($urandom_range(CHAR_LAST, CHAR_FIRST));
        send_request(REQ_PRINT, code, page, column);
      end else if (pick < 60) begin
        send_request(REQ_PRINT, ($urandom_range(1) != 0) ? CHAR_CR : CHAR_LF, page, column);
      end else if (pick < 72) begin
        send_request(REQ_PRINT, code, page, column);
      end else if (pick < 86) begin
        page   = 8'($urandom_range(PAGE_COUNT - 1));
        column = ($urandom_range(1) != 0) ? 8'($urandom_range(COLUMN_COUNT - 1, 110))
                                          : 8'($urandom_range(COLUMN_COUNT - 1));
        send_request(REQ_SET_CURSOR, code, page, column);
      end else begin
        send_request(REQ_SET_CURSOR, code, page, column);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    req_type      = REQ_PRINT;
    char_code     = 8'h00;
    page_sel      = 8'h00;
    column_sel    = 8'h00;
    error_count   = 0;
    cursor_page   = '0;
    cursor_column = '0;
    send_idle_pct = 26;
    recv_idle_pct = 70;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_glyph_extremes();
    test_new_line();
    test_cursor_set();
    test_line_wrap();

    // Drain fully once before the random part
    hold_until_drained();
    test_random_traffic(RANDOM_PER_PHASE);

    send_idle_pct = 70;
    recv_idle_pct = 26;
    test_random_traffic(RANDOM_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_PER_PHASE);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== oled_text_glyph_streamer.f =====
rtl/core/ogs_pkg.sv
rtl/core/ogs_font_rom.sv
rtl/core/ogs_seq.sv
rtl/core/oled_text_glyph_streamer.sv
verif/tb.sv
